// ----- sv/stc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: shared definitions for the level trigger capture block
// Types, codes and default sizes used by the front end, the job queue and
// the result back end.
// ----------------------------------------------------------------------------
package stc_pkg;

   // default capture length and job queue depth
   localparam int CAPTURE_LENGTH_DEF = 200;
   localparam int QUEUE_DEPTH_DEF    = 4;

   // trigger level after reset
   localparam logic [7:0] TRIGGER_RESET = 8'd128;

   // request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REARM  = 1'b1;

   // trigger phase codes
   localparam logic [2:0] PH_SEARCH  = 3'd0;
   localparam logic [2:0] PH_FIRST   = 3'd1;
   localparam logic [2:0] PH_SECOND  = 3'd2;
   localparam logic [2:0] PH_CAPTURE = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   // one job from front to back: a single sample or the three trigger samples
   typedef struct packed {
      logic       triple;
      logic [7:0] val0;
      logic [7:0] val1;
      logic [7:0] val2;
      logic [7:0] idx;
   } stc_job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } stc_qstat_type;

endpackage
`default_nettype wire

// ----- sv/scope_trigger_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_trigger_capture: level trigger and streamed capture
// Watches an 8-bit sample stream for the trigger level, qualifies it by two
// following samples, then streams CAPTURE_LENGTH samples with their indices.
// ----------------------------------------------------------------------------
// The block takes one request word per clock while its job queue has room
// (QUEUE_DEPTH jobs); result words leave at one per clock, while rsp_ready
// is high, through a registered output. Each captured sample yields one
// result word, except the qualifying sample, which releases the three trigger
// samples as three result words; the queue absorbs that burst, so with the
// result side always ready the input sees at most a short stall right after the trigger.
// Rearm words clear the trigger and capture state; trigger_level survives.
// Write the trigger level only while no results are outstanding.
module scope_trigger_capture
   import stc_pkg::*;
#(
   parameter int CAPTURE_LENGTH = CAPTURE_LENGTH_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_op,
   input  wire logic [7:0] req_sample,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_captured_value,
   output logic [7:0]      rsp_capture_index,
   output logic            rsp_last_of_capture,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   localparam logic [7:0] LAST_IDX = 8'(CAPTURE_LENGTH - 1);

   stc_qstat_type q_stat;
   stc_job_type   push_job;
   stc_job_type   head_job;
   logic          job_push;
   logic          job_pop;

   // front end: intake and trigger qualifier
   stc_front #(
      .CAPTURE_LENGTH (CAPTURE_LENGTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_sample  (req_sample),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_stat      (q_stat),
      .job_push    (job_push),
      .job         (push_job)
   );

   // job queue
   stc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   // back end: result words
   stc_back #(
      .CAPTURE_LENGTH (CAPTURE_LENGTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_job            (head_job),
      .q_stat              (q_stat),
      .pop                 (job_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_captured_value  (rsp_captured_value),
      .rsp_capture_index   (rsp_capture_index),
      .rsp_last_of_capture (rsp_last_of_capture)
   );

   // last flag only on the final capture position
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_capture == (rsp_capture_index == LAST_IDX)))
      else $error("last flag does not match capture index");

   // no index past the capture length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_capture_index <= LAST_IDX))
      else $error("capture index beyond capture length");

   // queue never written when full, never drained when empty
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !(job_push && q_stat.full) && !(job_pop && q_stat.empty))
      else $error("job queue overflow or underflow");

endmodule
`default_nettype wire

// ----- sv/stc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_queue: job queue between front end and back end
// Small show-ahead fifo of capture jobs; lets each side stall on its own.
// ----------------------------------------------------------------------------
module stc_queue
   import stc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire stc_job_type   push_job,
   input  wire logic          pop,
   output stc_job_type        head_job,
   output stc_qstat_type      stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   stc_job_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = slot_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_FULL);

endmodule
`default_nettype wire

// ----- sv/stc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_front: request intake and trigger detection
// Accepts sample and rearm words, runs the trigger qualifier and capture
// counter, and queues capture jobs for the back end.
// ----------------------------------------------------------------------------
module stc_front
   import stc_pkg::*;
#(
   parameter int CAPTURE_LENGTH = CAPTURE_LENGTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_op,
   input  wire logic [7:0]    req_sample,
   input  wire logic          csr_wr_en,
   input  wire logic [7:0]    csr_wr_data,
   input  wire stc_qstat_type q_stat,
   output logic               job_push,
   output stc_job_type        job
);

   localparam logic [8:0] LEN_W = 9'(CAPTURE_LENGTH);

   logic [7:0] trigger_ff, trigger_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic [7:0] count_ff, count_in;
   logic       accept;
   logic       not_below;
   logic [8:0] count_next;

   assign req_ready  = !q_stat.full;
   assign accept     = req_valid && req_ready;
   assign not_below  = (req_sample >= first_ff);
   assign count_next = {1'b0, count_ff} + 9'd1;

   // trigger level register
   always_comb begin
      trigger_in = trigger_ff;
      if (csr_wr_en) begin
         trigger_in = csr_wr_data;
      end
   end

   // trigger qualifier and capture sequencing
   always_comb begin
      phase_in    = phase_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      count_in    = count_ff;
      job_push    = 1'b0;
      job.triple  = 1'b0;
      job.val0    = req_sample;
      job.val1    = second_ff;
      job.val2    = req_sample;
      job.idx     = count_ff;
      if (accept) begin
         if (req_op == OP_REARM) begin
            phase_in  = PH_SEARCH;
            first_in  = '0;
            second_in = '0;
            count_in  = '0;
         end else begin
            unique case (phase_ff)
               PH_SEARCH: begin
                  if (req_sample == trigger_ff) begin
                     first_in = req_sample;
                     phase_in = PH_FIRST;
                  end
               end
               PH_FIRST: begin
                  if (not_below) begin
                     second_in = req_sample;
                     phase_in  = PH_SECOND;
                  end else begin
                     phase_in = PH_SEARCH;
                  end
               end
               PH_SECOND: begin
                  if (not_below) begin
                     job_push   = 1'b1;
                     job.triple = 1'b1;
                     job.val0   = first_ff;
                     job.idx    = '0;
                     count_in   = 8'd3;
                     phase_in   = (LEN_W <= 9'd3) ? PH_DONE : PH_CAPTURE;
                  end else begin
                     phase_in = PH_SEARCH;
                  end
               end
               PH_CAPTURE: begin
                  job_push = 1'b1;
                  count_in = count_next[7:0];
                  if (count_next >= LEN_W) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  // done: samples are dropped until rearm
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff <= TRIGGER_RESET;
         phase_ff   <= PH_SEARCH;
         first_ff   <= '0;
         second_ff  <= '0;
         count_ff   <= '0;
      end else begin
         trigger_ff <= trigger_in;
         phase_ff   <= phase_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/stc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_back: result word generation
// Drains capture jobs from the queue, one result word per cycle while rsp_ready
// allows, into the registered result channel; a trigger job yields three words.
// ----------------------------------------------------------------------------
module stc_back
   import stc_pkg::*;
#(
   parameter int CAPTURE_LENGTH = CAPTURE_LENGTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stc_job_type   head_job,
   input  wire stc_qstat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_captured_value,
   output logic [7:0]         rsp_capture_index,
   output logic               rsp_last_of_capture
);

   localparam logic [8:0] LEN_W = 9'(CAPTURE_LENGTH);

   logic       valid_ff, valid_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] value_ff, value_in;
   logic [7:0] index_ff, index_in;
   logic       last_ff, last_in;
   logic       load;
   logic       job_done;
   logic [8:0] idx_k;

   // slot within the current job and its index
   assign idx_k    = {1'b0, head_job.idx} + {7'd0, slot_ff};
   assign job_done = !head_job.triple || (slot_ff == 2'd2);
   assign load     = !valid_ff || rsp_ready;
   assign pop      = load && !q_stat.empty && job_done;

   // output register next values
   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      value_in = value_ff;
      index_in = index_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            case (slot_ff)
               2'd0:    value_in = head_job.val0;
               2'd1:    value_in = head_job.val1;
               default: value_in = head_job.val2;
            endcase
            index_in = idx_k[7:0];
            last_in  = ((idx_k + 9'd1) >= LEN_W);
            slot_in  = job_done ? 2'd0 : slot_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_captured_value  = value_ff;
   assign rsp_capture_index   = index_ff;
   assign rsp_last_of_capture = last_ff;

endmodule
`default_nettype wire

// ----- bench/scope_trigger_capture_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_trigger_capture_test: self-checking bench for the level trigger capture
// Drives sample and rearm words with random gaps on both handshakes, tracks
// the trigger and capture state in the bench itself and compares every
// captured word field by field against the words it predicts.
// ----------------------------------------------------------------------------
module scope_trigger_capture_test;
   import stc_pkg::*;

   // capture length as built by default
   localparam int CAP_LEN     = CAPTURE_LENGTH_DEF;
   localparam int SETTLE      = QUEUE_DEPTH_DEF + 4;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] index;
      logic       last;
   } capture_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_op = OP_SAMPLE;
   logic [7:0] req_sample = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_captured_value;
   logic [7:0] rsp_capture_index;
   logic       rsp_last_of_capture;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   // bench copy of the trigger and capture state
   logic [7:0] level_now;
   logic [2:0] trig_phase;
   logic [7:0] held_first;
   logic [7:0] held_second;
   logic [7:0] capture_count;

   capture_word_type capture_words_due[$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int               sender_idle_pct = 14;
   int               receiver_idle_pct = 53;

   scope_trigger_capture #(
      .CAPTURE_LENGTH(CAP_LEN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_captured_value  (rsp_captured_value),
      .rsp_capture_index   (rsp_capture_index),
      .rsp_last_of_capture (rsp_last_of_capture),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #5 clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // clear trigger and capture state, level is kept
   function automatic void clear_trigger();
      trig_phase    = PH_SEARCH;
      held_first    = 8'd0;
      held_second   = 8'd0;
      capture_count = 8'd0;
   endfunction

   // queue one captured word and advance the capture position
   function automatic void push_capture_word(input logic [7:0] value);
      capture_word_type w;
      w.value = value;
      w.index = capture_count;
      w.last  = (capture_count + 1 >= CAP_LEN);
      capture_words_due.push_back(w);
      capture_count = capture_count + 8'd1;
   endfunction

   // advance the trigger state by one accepted word
   function automatic void track_request(input logic op, input logic [7:0] s);
      if (op == OP_REARM) begin
         clear_trigger();
      end else begin
         case (trig_phase)
            PH_SEARCH: begin
               if (s == level_now) begin
                  held_first = s;
                  trig_phase = PH_FIRST;
               end
            end
            PH_FIRST: begin
               if (s >= held_first) begin
                  held_second = s;
                  trig_phase  = PH_SECOND;
               end else begin
                  trig_phase = PH_SEARCH;
               end
            end
            PH_SECOND: begin
               if (s >= held_first) begin
                  capture_count = 8'd0;
                  push_capture_word(held_first);
                  push_capture_word(held_second);
                  push_capture_word(s);
                  trig_phase = (capture_count >= CAP_LEN) ? PH_DONE : PH_CAPTURE;
               end else begin
                  trig_phase = PH_SEARCH;
               end
            end
            PH_CAPTURE: begin
               push_capture_word(s);
               if (capture_count >= CAP_LEN) trig_phase = PH_DONE;
            end
            default: ;
         endcase
      end
   endfunction

   // track accepted words, check results, watch for a hang
   always @(posedge clock) begin : monitor
      capture_word_type w;
      if (reset) begin
         level_now = TRIGGER_RESET;
         clear_trigger();
      end else begin
         if (csr_wr_en) level_now = csr_wr_data;
         if (req_valid && req_ready) track_request(req_op, req_sample);
         if (rsp_valid && rsp_ready) begin
            if (capture_words_due.size() == 0) begin
               $error("unexpected word: captured_value %0d capture_index %0d",
                      rsp_captured_value, rsp_capture_index);
               mismatch_count++;
            end else begin
               w = capture_words_due.pop_front();
               if (rsp_captured_value !== w.value) begin
                  $error("captured_value expected %0d got %0d", w.value, rsp_captured_value);
                  mismatch_count++;
               end
               if (rsp_capture_index !== w.index) begin
                  $error("capture_index expected %0d got %0d", w.index, rsp_capture_index);
                  mismatch_count++;
               end
               if (rsp_last_of_capture !== w.last) begin
                  $error("last_of_capture expected %0d got %0d", w.last,
                         rsp_last_of_capture);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("scope_trigger_capture_test: done, errors");
            $finish;
         end
      end
   end

   // offer one word, with a random gap first, and hold it until taken
   task automatic send_word(input logic op, input logic [7:0] s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and wait until every predicted word has come out
   task automatic wait_capture_drained();
      req_valid <= 1'b0;
      while (capture_words_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_trigger_level(input logic [7:0] level);
      wait_capture_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // reset level: trigger, a run of captured samples, rearm mid-capture
   task automatic test_default_level();
      send_word(OP_SAMPLE, 8'd128);
      send_word(OP_SAMPLE, 8'd128);
      send_word(OP_SAMPLE, 8'd255);
      send_word(OP_SAMPLE, 8'd0);
      send_word(OP_SAMPLE, 8'd255);
      send_word(OP_SAMPLE, 8'd1);
      send_word(OP_SAMPLE, 8'd128);
      send_word(OP_SAMPLE, 8'd254);
      send_word(OP_SAMPLE, 8'd128);
      send_word(OP_REARM, 8'd255);
   endtask

   // second and third samples below the first, write while armed, rearm mid-capture
   task automatic test_failing_qualifier();
      set_trigger_level(8'd50);
      send_word(OP_SAMPLE, 8'd50);
      send_word(OP_SAMPLE, 8'd49);
      send_word(OP_SAMPLE, 8'd50);
      send_word(OP_SAMPLE, 8'd60);
      send_word(OP_SAMPLE, 8'd10);
      send_word(OP_SAMPLE, 8'd50);
      // level change keeps the held first sample
      set_trigger_level(8'd77);
      send_word(OP_SAMPLE, 8'd50);
      send_word(OP_SAMPLE, 8'd51);
      send_word(OP_REARM, 8'd0);
      send_word(OP_SAMPLE, 8'd77);
      send_word(OP_REARM, 8'd0);
   endtask

   // lowest and highest trigger levels
   task automatic test_level_extremes();
      set_trigger_level(8'd0);
      send_word(OP_SAMPLE, 8'd0);
      send_word(OP_SAMPLE, 8'd0);
      send_word(OP_SAMPLE, 8'd0);
      send_word(OP_REARM, 8'd0);
      set_trigger_level(8'd255);
      send_word(OP_SAMPLE, 8'd255);
      send_word(OP_SAMPLE, 8'd255);
      send_word(OP_SAMPLE, 8'd255);
      send_word(OP_REARM, 8'd127);
   endtask

   // mostly trigger sequences with random content, plus noise and broken ones
   task automatic test_random_stream(input int words, input int send_pct, input int recv_pct);
      int         sent;
      int         roll;
      logic       op;
      logic [7:0] s;
      set_trigger_level(8'($urandom_range(255)));
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      sent = 0;
      while (sent < words) begin
         roll = $urandom_range(99);
         op   = OP_SAMPLE;
         s    = 8'($urandom_range(255));
         case (trig_phase)
            PH_SEARCH: begin
               if (roll < 70) s = level_now;
               else if (roll >= 95) op = OP_REARM;
            end
            PH_FIRST, PH_SECOND: begin
               if (roll < 85) s = 8'($urandom_range(255, held_first));
               else if (roll < 95 && held_first != 0) s = 8'($urandom_range(held_first - 1, 0));
               else if (roll >= 95) op = OP_REARM;
            end
            PH_CAPTURE: begin
               if (roll >= 95) op = OP_REARM;
            end
            default: begin
               if (roll < 80) op = OP_REARM;
            end
         endcase
         if (!(trig_phase == PH_DONE && op == OP_SAMPLE)) sent++;
         send_word(op, s);
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_level();
      test_failing_qualifier();
      test_level_extremes();
      test_random_stream(50, 14, 53);
      test_random_stream(50, 53, 14);
      test_random_stream(50, 0, 0);
      wait_capture_drained();
      if (mismatch_count == 0) begin
         $display("scope_trigger_capture_test: done, clean");
      end else begin
         $display("scope_trigger_capture_test: done, errors");
      end
      $finish;
   end

endmodule
